[src/tce_pkg.sv]
`default_nettype none

package tce_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 24;

  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_1      = 8'h31;
  localparam logic [CHAR_W-1:0] CH_2      = 8'h32;
  localparam logic [CHAR_W-1:0] CH_3      = 8'h33;
  localparam logic [CHAR_W-1:0] CH_4      = 8'h34;
  localparam logic [CHAR_W-1:0] CH_7      = 8'h37;
  localparam logic [CHAR_W-1:0] CH_J      = 8'h4a;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h6d;

  localparam logic [ATTR_W-1:0] ATTR_NORMAL  = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_BRIGHT  = 8'h0f;
  localparam logic [ATTR_W-1:0] ATTR_REVERSE = 8'h70;
  localparam logic [ATTR_W-1:0] FG_MASK      = 8'h0f;
  localparam logic [ATTR_W-1:0] BG_MASK      = 8'hf0;

  // escape parser phase
  typedef enum logic [4:0] {
    PH_NONE   = 5'b00001,
    PH_ESC    = 5'b00010,
    PH_CSI    = 5'b00100,
    PH_SEL    = 5'b01000,
    PH_COLOUR = 5'b10000
  } phase_e;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DONE   = 5'b10000
  } ctl_state_e;

  typedef struct packed {
    logic put_go;
    logic read_go;
    logic fill_start;
    logic fill_step;
    logic fill_blank;
    logic scroll_start;
    logic scroll_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic put_clear;
    logic put_scroll;
    logic fill_last;
    logic scroll_last;
    logic out_free;
  } ctl_sts_t;

  // ANSI colour number to VGA palette index
  function automatic logic [3:0] vga_colour(input logic [2:0] ansi);
    logic [3:0] v;
    unique case (ansi)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd4;
      3'd2:    v = 4'd2;
      3'd3:    v = 4'd14;
      3'd4:    v = 4'd1;
      3'd5:    v = 4'd5;
      3'd6:    v = 4'd3;
      default: v = 4'd15;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/tce_req_if.sv]
`default_nettype none

interface tce_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input req_type, input char_code, input cell_index,
                  output ready);
endinterface

`default_nettype wire

[src/tce_rsp_if.sv]
`default_nettype none

interface tce_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic [10:0] cursor_now;
  logic [7:0]  attr_now;

  modport source (output valid, output cell_char, output cell_attr, output cursor_now,
                  output attr_now, input ready);
  modport sink   (input valid, input cell_char, input cell_attr, input cursor_now,
                  input attr_now, output ready);
endinterface

`default_nettype wire

[src/text_console_escape_engine_top.sv]
// Channel  Direction  Interface   Payload
// req_i    in         tce_req_if  req_type, char_code, cell_index
// rsp_o    out        tce_rsp_if  cell_char, cell_attr, cursor_now, attr_now
//
// Reads and ordinary puts: accept, then load of the result register once it is free.
// ESC [2J fills the store with blanks (one cell written per cycle on the write port).
// A put that passes the last row scrolls the whole store: the single read port
// copies one cell per cycle, then the last row is zeroed in the same sweep.
// After reset the whole store is zeroed, cell by cell; no input
// transaction is taken until then.
// The result register holds a finished transaction while the next input is taken;
// a stalled output blocks only the completion of the following transaction.
`default_nettype none

module text_console_escape_engine_top #(
  parameter int unsigned COLUMNS = tce_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tce_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tce_req_if.sink     req_i,
  tce_rsp_if.source   rsp_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  tce_pkg::ctl_cmd_t cmd;
  tce_pkg::ctl_sts_t sts;

  tce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  tce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .char_code_i  (req_i.char_code),
    .cell_index_i (req_i.cell_index),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .cell_char_o  (rsp_o.cell_char),
    .cell_attr_o  (rsp_o.cell_attr),
    .cursor_now_o (rsp_o.cursor_now),
    .attr_now_o   (rsp_o.attr_now)
  );

  // one transaction in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("input taken while a transaction is in flight");

  // datapath commands never overlap on the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.put_go, cmd.read_go, cmd.fill_step, cmd.scroll_step, cmd.out_load}))
    else $error("overlapping datapath commands");

  // a completed transaction shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_o.valid)
    else $error("result not presented after load");

  // the cursor never rests past the last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (32'(rsp_o.cursor_now) < CELLS))
    else $error("cursor out of range");

endmodule

`default_nettype wire

[src/tce_datapath.sv]
`default_nettype none

module tce_datapath #(
  parameter int unsigned COLUMNS = tce_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tce_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tce_pkg::ctl_cmd_t           cmd_i,
  output tce_pkg::ctl_sts_t           sts_o,
  input  logic [tce_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tce_pkg::IDX_W-1:0]   cell_index_i,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic [tce_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [tce_pkg::ATTR_W-1:0]  cell_attr_o,
  output logic [tce_pkg::IDX_W-1:0]   cursor_now_o,
  output logic [tce_pkg::ATTR_W-1:0]  attr_now_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned CUR_W  = $clog2(CELLS + 4);
  localparam int unsigned COL_W  = $clog2(COLUMNS + 4);
  localparam int unsigned ROW_W  = $clog2(ROWS + 1);
  localparam int unsigned SW_W   = $clog2(CELLS + COLUMNS);
  localparam int unsigned XW     = (AW > tce_pkg::IDX_W) ? AW : tce_pkg::IDX_W;
  localparam int unsigned CELL_W = tce_pkg::CHAR_W + tce_pkg::ATTR_W;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  logic [CUR_W-1:0]          cursor_q, cur_n;
  logic [COL_W-1:0]          col_q, col_n, col_t;
  logic [ROW_W-1:0]          row_q, row_n;
  logic [tce_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic [3:0]                pend_q, pend_d;
  tce_pkg::phase_e           phase_q, phase_d;
  logic [tce_pkg::CHAR_W-1:0] sel_q, sel_d;
  logic                      consumed, clear_hit, scroll_hit, put_wr;

  logic [SW_W-1:0]  sweep_q;
  logic             copy_vld_q, copy_zero_q;
  logic [AW-1:0]    copy_addr_q;
  logic             rd_item_q, in_range_q;

  logic [XW-1:0]     idx_x;
  logic              in_range;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [tce_pkg::CHAR_W-1:0] c;
  assign c = char_code_i;

  // escape parser and cursor movement for one put transaction
  always_comb begin
    phase_d    = phase_q;
    sel_d      = sel_q;
    pend_d     = pend_q;
    attr_d     = attr_q;
    consumed   = 1'b0;
    clear_hit  = 1'b0;
    scroll_hit = 1'b0;
    put_wr     = 1'b0;
    cur_n      = cursor_q;
    col_n      = col_q;
    row_n      = row_q;
    col_t      = col_q + COL_W'(4) - COL_W'(cursor_q[1:0]);

    unique case (phase_q)
      tce_pkg::PH_ESC: begin
        if (c == tce_pkg::CH_LBRACK) begin
          phase_d  = tce_pkg::PH_CSI;
          consumed = 1'b1;
        end
      end
      tce_pkg::PH_CSI: begin
        if (c == tce_pkg::CH_0 || c == tce_pkg::CH_1 || c == tce_pkg::CH_2 ||
            c == tce_pkg::CH_3 || c == tce_pkg::CH_4 || c == tce_pkg::CH_7) begin
          sel_d    = c;
          phase_d  = tce_pkg::PH_SEL;
          consumed = 1'b1;
        end
      end
      tce_pkg::PH_SEL: begin
        if (c >= tce_pkg::CH_0 && c <= tce_pkg::CH_7) begin
          if (sel_q == tce_pkg::CH_3 || sel_q == tce_pkg::CH_4) begin
            pend_d   = tce_pkg::vga_colour(c[2:0]);
            phase_d  = tce_pkg::PH_COLOUR;
            consumed = 1'b1;
          end
        end else if (c == tce_pkg::CH_J) begin
          if (sel_q == tce_pkg::CH_2) begin
            clear_hit = 1'b1;
            phase_d   = tce_pkg::PH_NONE;
            consumed  = 1'b1;
          end
        end else if (c == tce_pkg::CH_M) begin
          if (sel_q == tce_pkg::CH_0) begin
            attr_d = tce_pkg::ATTR_NORMAL;  phase_d = tce_pkg::PH_NONE; consumed = 1'b1;
          end else if (sel_q == tce_pkg::CH_1) begin
            attr_d = tce_pkg::ATTR_BRIGHT;  phase_d = tce_pkg::PH_NONE; consumed = 1'b1;
          end else if (sel_q == tce_pkg::CH_7) begin
            attr_d = tce_pkg::ATTR_REVERSE; phase_d = tce_pkg::PH_NONE; consumed = 1'b1;
          end
        end
      end
      tce_pkg::PH_COLOUR: begin
        if (c == tce_pkg::CH_M && sel_q == tce_pkg::CH_3) begin
          attr_d   = (attr_q & tce_pkg::BG_MASK) | {4'h0, pend_q};
          phase_d  = tce_pkg::PH_NONE;
          consumed = 1'b1;
        end else if (c == tce_pkg::CH_M && sel_q == tce_pkg::CH_4) begin
          attr_d   = (attr_q & tce_pkg::FG_MASK) | {pend_q, 4'h0};
          phase_d  = tce_pkg::PH_NONE;
          consumed = 1'b1;
        end
      end
      default: ;
    endcase

    if (!consumed) begin
      if (c == tce_pkg::CH_ESC) begin
        phase_d = tce_pkg::PH_ESC;
      end else begin
        phase_d = tce_pkg::PH_NONE;
        unique case (c)
          tce_pkg::CH_CR: begin
            cur_n = cursor_q - CUR_W'(col_q);
            col_n = '0;
          end
          tce_pkg::CH_LF: begin
            cur_n = cursor_q + CUR_W'(COLUMNS) - CUR_W'(col_q);
            col_n = '0;
            row_n = row_q + ROW_W'(1);
          end
          tce_pkg::CH_TAB: begin
            cur_n = {cursor_q[CUR_W-1:2], 2'b00} + CUR_W'(4);
            if (col_t >= COL_W'(COLUMNS)) begin
              col_n = col_t - COL_W'(COLUMNS);
              row_n = row_q + ROW_W'(1);
            end else begin
              col_n = col_t;
            end
          end
          tce_pkg::CH_BS: begin
            // hold at the first cell
            if (cursor_q != '0) begin
              cur_n = cursor_q - CUR_W'(1);
              if (col_q == '0) begin
                col_n = COL_W'(COLUMNS - 1);
                row_n = row_q - ROW_W'(1);
              end else begin
                col_n = col_q - COL_W'(1);
              end
            end
          end
          default: begin
            put_wr = (cursor_q < CUR_W'(CELLS));
            cur_n  = cursor_q + CUR_W'(1);
            if (col_q == COL_W'(COLUMNS - 1)) begin
              col_n = '0;
              row_n = row_q + ROW_W'(1);
            end else begin
              col_n = col_q + COL_W'(1);
            end
          end
        endcase
        if (row_n == ROW_W'(ROWS)) begin
          scroll_hit = 1'b1;
          cur_n      = cur_n - CUR_W'(COLUMNS);
          row_n      = ROW_W'(ROWS - 1);
        end
      end
    end

    if (clear_hit) begin
      cur_n = '0;
      col_n = '0;
      row_n = '0;
    end
  end

  assign idx_x    = XW'(cell_index_i);
  assign in_range = (idx_x < XW'(CELLS));

  assign sts_o.put_clear   = clear_hit;
  assign sts_o.put_scroll  = scroll_hit;
  assign sts_o.fill_last   = (sweep_q == SW_W'(CELLS - 1));
  assign sts_o.scroll_last = (sweep_q == SW_W'(CELLS + COLUMNS - 1));
  assign sts_o.out_free    = !rsp_valid_o || rsp_ready_i;

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = copy_addr_q;
    mem_wdata = copy_zero_q ? '0 : rdata_q;
    if (cmd_i.put_go) begin
      mem_we    = put_wr;
      mem_waddr = AW'(cursor_q);
      mem_wdata = {attr_q, c};
    end else if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(sweep_q);
      mem_wdata = cmd_i.fill_blank ? {attr_q, tce_pkg::CH_SPACE} : '0;
    end else if (copy_vld_q) begin
      mem_we    = 1'b1;
    end
    mem_re    = cmd_i.read_go || (cmd_i.scroll_step && (sweep_q < SW_W'(CELLS)));
    mem_raddr = cmd_i.read_go ? (in_range ? AW'(idx_x) : '0) : AW'(sweep_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      attr_q   <= tce_pkg::ATTR_NORMAL;
      pend_q   <= '0;
      phase_q  <= tce_pkg::PH_NONE;
      sel_q    <= '0;
    end else if (cmd_i.put_go) begin
      cursor_q <= cur_n;
      col_q    <= col_n;
      row_q    <= row_n;
      attr_q   <= attr_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      sel_q    <= sel_d;
    end
  end

  // sweep counter and delayed write stage of the scroll copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q    <= '0;
      copy_vld_q <= 1'b0;
      rd_item_q  <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      if (cmd_i.fill_start) begin
        sweep_q <= '0;
      end else if (cmd_i.scroll_start) begin
        sweep_q <= SW_W'(COLUMNS);
      end else if (cmd_i.fill_step || cmd_i.scroll_step) begin
        sweep_q <= sweep_q + SW_W'(1);
      end
      copy_vld_q <= cmd_i.scroll_step;
      if (cmd_i.read_go) begin
        rd_item_q  <= 1'b1;
        in_range_q <= in_range;
      end else if (cmd_i.put_go) begin
        rd_item_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= AW'(sweep_q - SW_W'(COLUMNS));
    copy_zero_q <= (sweep_q >= SW_W'(CELLS));
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_o <= 1'b0;
    end else begin
      rsp_valid_o <= cmd_i.out_load || (rsp_valid_o && !rsp_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_char_o  <= (rd_item_q && in_range_q) ? rdata_q[tce_pkg::CHAR_W-1:0] : '0;
      cell_attr_o  <= (rd_item_q && in_range_q) ? rdata_q[CELL_W-1:tce_pkg::CHAR_W] : '0;
      cursor_now_o <= tce_pkg::IDX_W'(cursor_q);
      attr_now_o   <= attr_q;
    end
  end

endmodule

`default_nettype wire

[src/tce_ctrl.sv]
`default_nettype none

module tce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_type_i,
  input  tce_pkg::ctl_sts_t sts_i,
  output logic              req_ready_o,
  output tce_pkg::ctl_cmd_t cmd_o
);

  tce_pkg::ctl_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      tce_pkg::ST_INIT: begin
        // zero the screen store after reset
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = tce_pkg::ST_IDLE;
        end
      end
      tce_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_i) begin
            cmd_o.read_go = 1'b1;
            state_d       = tce_pkg::ST_DONE;
          end else begin
            cmd_o.put_go = 1'b1;
            if (sts_i.put_clear) begin
              cmd_o.fill_start = 1'b1;
              state_d          = tce_pkg::ST_FILL;
            end else if (sts_i.put_scroll) begin
              cmd_o.scroll_start = 1'b1;
              state_d            = tce_pkg::ST_SCROLL;
            end else begin
              state_d = tce_pkg::ST_DONE;
            end
          end
        end
      end
      tce_pkg::ST_FILL: begin
        cmd_o.fill_step  = 1'b1;
        cmd_o.fill_blank = 1'b1;
        if (sts_i.fill_last) begin
          state_d = tce_pkg::ST_DONE;
        end
      end
      tce_pkg::ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (sts_i.scroll_last) begin
          state_d = tce_pkg::ST_DONE;
        end
      end
      tce_pkg::ST_DONE: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = tce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tce_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
